// File: src/rmq_pkg.sv
// Shared widths, limits and codes for the rotation matrix to quaternion block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  localparam int IN_W  = 18;
  localparam int OUT_W = 18;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  typedef enum logic [1:0] {
    WIN_W = 2'd0,
    WIN_X = 2'd1,
    WIN_Y = 2'd2,
    WIN_Z = 2'd3
  } win_e;
endpackage
`default_nettype wire

// File: src/rotation_matrix_to_quaternion.sv
// Top level: converts a 3x3 rotation matrix into a normalized quaternion.
// Depends on rmq_pkg and rmq_lane.
`timescale 1ns / 1ps
`default_nettype none
// The block accepts one matrix every cycle while the output is not stalled and
// returns one quaternion per matrix, in order. Each of the four parallel lanes
// is a divider with one quotient bit per stage followed by a square root with
// one result bit per stage. The whole pipeline holds while a result waits to
// be taken. Magnitudes are truncated, not rounded.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [rmq_pkg::IN_W-1:0] row0_col0_i,
  input  logic signed [rmq_pkg::IN_W-1:0] row0_col1_i,
  input  logic signed [rmq_pkg::IN_W-1:0] row0_col2_i,
  input  logic signed [rmq_pkg::IN_W-1:0] row1_col0_i,
  input  logic signed [rmq_pkg::IN_W-1:0] row1_col1_i,
  input  logic signed [rmq_pkg::IN_W-1:0] row1_col2_i,
  input  logic signed [rmq_pkg::IN_W-1:0] row2_col0_i,
  input  logic signed [rmq_pkg::IN_W-1:0] row2_col1_i,
  input  logic signed [rmq_pkg::IN_W-1:0] row2_col2_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [rmq_pkg::OUT_W-1:0] quat_scalar_o,
  output logic signed [rmq_pkg::OUT_W-1:0] quat_x_o,
  output logic signed [rmq_pkg::OUT_W-1:0] quat_y_o,
  output logic signed [rmq_pkg::OUT_W-1:0] quat_z_o
);
  import rmq_pkg::*;

  localparam int BaseW = (FRAC_BITS > IN_W - 1) ? FRAC_BITS : IN_W - 1;
  localparam int SW    = BaseW + 4;
  localparam int TW    = SW + 2;
  localparam int LaneLat = 3 * FRAC_BITS + 1;
  localparam int VW    = (FRAC_BITS + 3 > OUT_W + 1) ? FRAC_BITS + 3 : OUT_W + 1;
  localparam logic signed [VW-1:0] VMax = VW'(OUT_MAX);
  localparam logic signed [VW-1:0] VMin = VW'(OUT_MIN);
  localparam logic signed [SW-1:0] One  = SW'(1) << FRAC_BITS;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: trace combinations and sign terms.
  logic signed [SW-1:0] s_q [4];
  logic dx_q, dy_q, dz_q, sxy_q, sxz_q, syz_q;
  logic signed [SW-1:0] r00, r11, r22;
  logic signed [IN_W:0] dx, dy, dz, sxy, sxz, syz;

  always_comb begin
    r00 = SW'(row0_col0_i);
    r11 = SW'(row1_col1_i);
    r22 = SW'(row2_col2_i);
    dx  = (IN_W+1)'(row2_col1_i) - (IN_W+1)'(row1_col2_i);
    dy  = (IN_W+1)'(row0_col2_i) - (IN_W+1)'(row2_col0_i);
    dz  = (IN_W+1)'(row1_col0_i) - (IN_W+1)'(row0_col1_i);
    sxy = (IN_W+1)'(row1_col0_i) + (IN_W+1)'(row0_col1_i);
    sxz = (IN_W+1)'(row0_col2_i) + (IN_W+1)'(row2_col0_i);
    syz = (IN_W+1)'(row2_col1_i) + (IN_W+1)'(row1_col2_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[0] <= One + r00 + r11 + r22;
      s_q[1] <= One + r00 - r11 - r22;
      s_q[2] <= One - r00 + r11 - r22;
      s_q[3] <= One - r00 - r11 + r22;
      dx_q  <= dx[IN_W];
      dy_q  <= dy[IN_W];
      dz_q  <= dz[IN_W];
      sxy_q <= sxy[IN_W];
      sxz_q <= sxz[IN_W];
      syz_q <= syz[IN_W];
    end
  end

  // Stage 2: clamp, total, winner and signs.
  logic [TW-1:0] t [4];
  logic [TW-1:0] t_q [4];
  logic [TW-1:0] total_q;
  logic          neg_q [4];
  logic          neg [4];
  win_e          win;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i] = s_q[i][SW-1] ? '0 : TW'(unsigned'(s_q[i]));
    end
    win = WIN_W;
    if (t[1] > t[0]) win = WIN_X;
    if (t[2] > t[(win == WIN_X) ? 1 : 0]) win = WIN_Y;
    if (t[3] > t[win]) win = WIN_Z;
    for (int i = 0; i < 4; i++) neg[i] = 1'b0;
    case (win)
      WIN_W: begin
        neg[1] = dx_q; neg[2] = dy_q; neg[3] = dz_q;
      end
      WIN_X: begin
        neg[0] = dx_q; neg[2] = sxy_q; neg[3] = sxz_q;
      end
      WIN_Y: begin
        neg[0] = dy_q; neg[1] = sxy_q; neg[3] = syz_q;
      end
      default: begin
        neg[0] = dz_q; neg[1] = sxz_q; neg[2] = syz_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        t_q[i]   <= t[i];
        neg_q[i] <= neg[i];
      end
      total_q <= t[0] + t[1] + t[2] + t[3];
    end
  end

  logic [FRAC_BITS:0] mag [4];
  logic               lneg [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    rmq_lane #(
      .FracBits(FRAC_BITS),
      .TotW    (TW)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .t_i    (t_q[l]),
      .total_i(total_q),
      .neg_i  (neg_q[l]),
      .mag_o  (mag[l]),
      .neg_o  (lneg[l])
    );
  end

  // Valid bits that track the data through both stages, the lanes and the
  // output register.
  logic [LaneLat+2:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LaneLat+1:0], in_valid_i};
    end
  end

  // Output register with sign and saturation.
  logic signed [OUT_W-1:0] q_d [4];
  logic signed [OUT_W-1:0] q_q [4];
  logic signed [VW-1:0]    sv [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sv[i] = signed'(VW'(mag[i]));
      if (lneg[i]) sv[i] = -sv[i];
      if (sv[i] > VMax) q_d[i] = OUT_W'(VMax);
      else if (sv[i] < VMin) q_d[i] = OUT_W'(VMin);
      else q_d[i] = sv[i][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) q_q[i] <= q_d[i];
    end
  end

  assign out_valid_o   = v_q[LaneLat+2];
  assign quat_scalar_o = q_q[0];
  assign quat_x_o      = q_q[1];
  assign quat_y_o      = q_q[2];
  assign quat_z_o      = q_q[3];
endmodule
`default_nettype wire

// File: src/rmq_lane.sv
// One quaternion component lane: pipelined restoring division of t by the total
// (one quotient bit per stage) followed by a pipelined integer square root.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_lane #(
  parameter int FracBits = 16,
  parameter int TotW     = 24
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [TotW-1:0]     t_i,
  input  logic [TotW-1:0]     total_i,
  input  logic                neg_i,
  output logic [FracBits:0]   mag_o,
  output logic                neg_o
);
  import rmq_pkg::*;

  localparam int DivN = 2 * FracBits;
  localparam int SqN  = FracBits + 1;
  localparam int XW   = DivN + 1;

  logic [TotW-1:0] rem_q [DivN];
  logic [TotW-1:0] den_q [DivN];
  logic [DivN-1:0] quo_q [DivN];
  logic            eq_q  [DivN];
  logic [XW-1:0]   x_q   [SqN];
  logic [XW-1:0]   res_q [SqN];
  logic            neg_q [DivN+SqN];

  for (genvar i = 0; i < DivN; i++) begin : g_div
    logic [TotW-1:0] rem_in, den_in, rem_d;
    logic [DivN-1:0] quo_in;
    logic            eq_in;
    logic [TotW:0]   sh, diff;
    logic            ge;
    if (i == 0) begin : g_first
      assign rem_in = t_i;
      assign den_in = total_i;
      assign quo_in = '0;
      assign eq_in  = (t_i >= total_i);
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign eq_in  = eq_q[i-1];
    end
    always_comb begin
      sh    = {rem_in, 1'b0};
      ge    = (sh >= {1'b0, den_in});
      diff  = sh - {1'b0, den_in};
      rem_d = ge ? diff[TotW-1:0] : sh[TotW-1:0];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        den_q[i] <= den_in;
        quo_q[i] <= {quo_in[DivN-2:0], ge};
        eq_q[i]  <= eq_in;
      end
    end
  end

  for (genvar j = 0; j < SqN; j++) begin : g_sqrt
    localparam logic [XW-1:0] Bit = XW'(1) << (2 * (FracBits - j));
    logic [XW-1:0] x_in, res_in, trial;
    logic          ge;
    if (j == 0) begin : g_first
      assign x_in   = eq_q[DivN-1] ? Bit : {1'b0, quo_q[DivN-1]};
      assign res_in = '0;
    end else begin : g_next
      assign x_in   = x_q[j-1];
      assign res_in = res_q[j-1];
    end
    always_comb begin
      trial = res_in + Bit;
      ge    = (x_in >= trial);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j]   <= ge ? (x_in - trial) : x_in;
        res_q[j] <= ge ? ((res_in >> 1) + Bit) : (res_in >> 1);
      end
    end
  end

  for (genvar k = 0; k < DivN + SqN; k++) begin : g_neg
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k] <= (k == 0) ? neg_i : neg_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign mag_o = res_q[SqN-1][FracBits:0];
  assign neg_o = neg_q[DivN+SqN-1];
endmodule
`default_nettype wire

// File: src/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion block, bound to the
// top level. Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic signed [rmq_pkg::OUT_W-1:0] quat_scalar_o,
  input logic signed [rmq_pkg::OUT_W-1:0] quat_x_o
);
  import rmq_pkg::*;

  // A held result beat keeps its valid, its scalar part and its x part.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quat_scalar_o)
      && $stable(quat_x_o))
    else $error("held result beat changed");

  // The input side is open whenever no result is waiting.
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  // The input stalls whenever a result is refused.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat right after reset");
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .quat_scalar_o(quat_scalar_o),
  .quat_x_o     (quat_x_o)
);
`default_nettype wire
